// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contact resolver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PCIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PCIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/pcir_pkg.sv
// ----------------------------------------------------------------------------
// pcir_pkg
// Widths, register codes and shared types of the contact impulse resolver.
// ----------------------------------------------------------------------------
package pcir_pkg;

  // Vector components and fixed-point scales
  localparam int unsigned CW   = 16;
  localparam int unsigned NF   = CW - 2;
  localparam int unsigned VW   = 3 * CW;
  localparam int unsigned IMW  = 16;
  localparam int unsigned PENW = 15;
  localparam int unsigned RSTW = 9;
  localparam int unsigned RSH  = 8;
  localparam int unsigned TSW  = 16;
  localparam int unsigned TW   = IMW + 1;

  // Datapath widths
  localparam int unsigned PRW  = 2 * CW + 1;
  localparam int unsigned DOTW = PRW + 2;
  localparam int unsigned SEPW = DOTW - NF;
  localparam int unsigned AFW  = DOTW + TSW + 1;
  localparam int unsigned ACCW = AFW - NF - TSW;
  localparam int unsigned NSMW = SEPW + RSTW + 2;
  localparam int unsigned NSW  = NSMW - RSH;
  localparam int unsigned ACRW = ACCW + RSTW + 1;
  localparam int unsigned DW   = SEPW + 2;
  localparam int unsigned NUMW = DW + IMW;
  localparam int unsigned MPW  = CW + DW + 1;
  localparam int unsigned SUMW = MPW - NF + 1;

  // Queue between front and back
  localparam int unsigned FQ_DEPTH = 4;

  // Register file
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned PAW       = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = '0;
  localparam logic [TSW-1:0] TS_RESET = 16'd1092;

  // Contact data carried along the pipeline
  typedef struct packed {
    logic [VW-1:0]   vel_a;
    logic [VW-1:0]   vel_b;
    logic [VW-1:0]   pos_a;
    logic [VW-1:0]   pos_b;
    logic [VW-1:0]   nrm;
    logic [IMW-1:0]  ima;
    logic [IMW-1:0]  imb;
    logic            has_b;
    logic [PENW-1:0] pen;
    logic [RSTW-1:0] rest;
  } ctx_t;

  // Classified contact handed from front to back
  typedef struct packed {
    ctx_t          ctx;
    logic [DW-1:0] delta;
    logic [TW-1:0] tot;
    logic          imp;
    logic          mov;
  } fq_t;

endpackage

// File: rtl/core/pcir_if.sv
// ----------------------------------------------------------------------------
// pcir request and result channels
// Valid/ready channels carrying one contact request and one result.
// ----------------------------------------------------------------------------
interface pcir_req_if;
  logic                          valid;
  logic                          ready;
  logic [pcir_pkg::VW-1:0]       vel_a;
  logic [pcir_pkg::VW-1:0]       vel_b;
  logic [pcir_pkg::VW-1:0]       accel_a;
  logic [pcir_pkg::VW-1:0]       accel_b;
  logic [pcir_pkg::VW-1:0]       pos_a;
  logic [pcir_pkg::VW-1:0]       pos_b;
  logic [pcir_pkg::VW-1:0]       contact_normal;
  logic [pcir_pkg::IMW-1:0]      inv_mass_a;
  logic [pcir_pkg::IMW-1:0]      inv_mass_b;
  logic                          has_second;
  logic [pcir_pkg::PENW-1:0]     penetration;
  logic [pcir_pkg::RSTW-1:0]     restitution;

  modport source (
    output valid, vel_a, vel_b, accel_a, accel_b, pos_a, pos_b, contact_normal,
           inv_mass_a, inv_mass_b, has_second, penetration, restitution,
    input  ready
  );
  modport sink (
    input  valid, vel_a, vel_b, accel_a, accel_b, pos_a, pos_b, contact_normal,
           inv_mass_a, inv_mass_b, has_second, penetration, restitution,
    output ready
  );
endinterface

interface pcir_res_if;
  logic                    valid;
  logic                    ready;
  logic [pcir_pkg::VW-1:0] new_vel_a;
  logic [pcir_pkg::VW-1:0] new_vel_b;
  logic [pcir_pkg::VW-1:0] new_pos_a;
  logic [pcir_pkg::VW-1:0] new_pos_b;
  logic                    impulse_applied;
  logic                    positions_moved;

  modport source (
    output valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b, impulse_applied,
           positions_moved,
    input  ready
  );
  modport sink (
    input  valid, new_vel_a, new_vel_b, new_pos_a, new_pos_b, impulse_applied,
           positions_moved,
    output ready
  );
endinterface

// File: rtl/core/pcir_front.sv
// ----------------------------------------------------------------------------
// pcir_front
// Accepts contact requests and classifies them: separating velocity,
// acceleration term, restitution target and velocity change.
// ----------------------------------------------------------------------------
module pcir_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pcir_pkg::TSW-1:0]  time_step_i,
  pcir_req_if.sink                  req_i,
  output logic                      push_o,
  output pcir_pkg::fq_t             push_data_o,
  input  logic                      push_ready_i
);
  import pcir_pkg::*;

  logic adv;
  logic [4:0] v_q;
  ctx_t in_ctx;

  logic signed [PRW-1:0] pv_d [3];
  logic signed [PRW-1:0] pa_d [3];
  logic signed [PRW-1:0] pv_q [3];
  logic signed [PRW-1:0] pa_q [3];
  ctx_t c1_q, c2_q, c3_q, c4_q;

  logic signed [DOTW-1:0] dv, da;
  logic [TW-1:0]          tot_d;
  logic signed [SEPW-1:0] sep2_q, sep3_q, sep4_q;
  logic signed [DOTW-1:0] dacc2_q;
  logic [TW-1:0]          tot2_q, tot3_q, tot4_q;

  logic signed [AFW-1:0]  accf_d, accf3_q;
  logic signed [NSMW-1:0] nsm_d, nsm3_q;
  logic signed [ACRW-1:0] acr_d, acr4_q;
  logic signed [NSW-1:0]  ns4_q;
  logic                   accneg4_q;
  fq_t                    fq_d, fq5_q;

  // Stall the whole front only when its last stage cannot enter the queue
  assign adv         = !v_q[4] || push_ready_i;
  assign req_i.ready = adv;
  assign push_o      = v_q[4];
  assign push_data_o = fq5_q;

  assign in_ctx.vel_a = req_i.vel_a;
  assign in_ctx.vel_b = req_i.vel_b;
  assign in_ctx.pos_a = req_i.pos_a;
  assign in_ctx.pos_b = req_i.pos_b;
  assign in_ctx.nrm   = req_i.contact_normal;
  assign in_ctx.ima   = req_i.inv_mass_a;
  assign in_ctx.imb   = req_i.inv_mass_b;
  assign in_ctx.has_b = req_i.has_second;
  assign in_ctx.pen   = req_i.penetration;
  assign in_ctx.rest  = req_i.restitution;

  // Relative velocity and acceleration products per component
  always_comb begin
    logic [CW-1:0]       ca, cb, ga, gb;
    logic signed [CW:0]  rv, ra;
    logic signed [CW-1:0] nn;
    for (int i = 0; i < 3; i++) begin
      ca = req_i.vel_a[i*CW +: CW];
      cb = req_i.vel_b[i*CW +: CW];
      ga = req_i.accel_a[i*CW +: CW];
      gb = req_i.accel_b[i*CW +: CW];
      nn = $signed(req_i.contact_normal[i*CW +: CW]);
      rv = $signed({ca[CW-1], ca});
      ra = $signed({ga[CW-1], ga});
      if (req_i.has_second) begin
        rv = rv - $signed({cb[CW-1], cb});
        ra = ra - $signed({gb[CW-1], gb});
      end
      pv_d[i] = rv * nn;
      pa_d[i] = ra * nn;
    end
  end

  // Dot products and total inverse mass
  assign dv = DOTW'(pv_q[0]) + DOTW'(pv_q[1]) + DOTW'(pv_q[2]);
  assign da = DOTW'(pa_q[0]) + DOTW'(pa_q[1]) + DOTW'(pa_q[2]);
  assign tot_d = TW'(c1_q.ima) + (c1_q.has_b ? TW'(c1_q.imb) : TW'(0));

  // Acceleration velocity over one step, restitution of the closing speed
  always_comb begin
    logic signed [SEPW:0] negs;
    negs   = -((SEPW+1)'(sep2_q));
    accf_d = dacc2_q * $signed({1'b0, time_step_i});
    nsm_d  = negs * $signed({1'b0, c2_q.rest});
  end

  // Restitution share of the acceleration term
  always_comb begin
    logic signed [ACCW-1:0] acc;
    acc   = $signed(accf3_q[AFW-1:NF+TSW]);
    acr_d = acc * $signed({1'b0, c3_q.rest});
  end

  // Target speed, clamp at zero, velocity change and flags
  always_comb begin
    logic signed [NSW:0]   ns2;
    logic signed [NSW+1:0] dfull;
    ns2 = (NSW+1)'(ns4_q);
    if (accneg4_q) begin
      ns2 = ns2 + (NSW+1)'($signed(acr4_q[ACRW-1:RSH]));
      if (ns2 < 0) begin
        ns2 = '0;
      end
    end
    dfull     = (NSW+2)'(ns2) - (NSW+2)'(sep4_q);
    fq_d.ctx   = c4_q;
    fq_d.delta = dfull[DW-1:0];
    fq_d.tot   = tot4_q;
    fq_d.imp   = (sep4_q[SEPW-1] || (sep4_q == '0)) && (tot4_q != '0);
    fq_d.mov   = (c4_q.pen != '0) && (tot4_q != '0);
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[3:0], req_i.valid};
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q      <= in_ctx;
      pv_q      <= pv_d;
      pa_q      <= pa_d;
      c2_q      <= c1_q;
      sep2_q    <= dv[DOTW-1:NF];
      dacc2_q   <= da;
      tot2_q    <= tot_d;
      c3_q      <= c2_q;
      sep3_q    <= sep2_q;
      tot3_q    <= tot2_q;
      accf3_q   <= accf_d;
      nsm3_q    <= nsm_d;
      c4_q      <= c3_q;
      sep4_q    <= sep3_q;
      tot4_q    <= tot3_q;
      ns4_q     <= nsm3_q[NSMW-1:RSH];
      accneg4_q <= accf3_q[AFW-1];
      acr4_q    <= acr_d;
      fq5_q     <= fq_d;
    end
  end

endmodule

// File: rtl/core/pcir_fifo.sv
// ----------------------------------------------------------------------------
// pcir_fifo
// Short queue of classified contacts between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcir_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcir_pkg::fq_t push_data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output pcir_pkg::fq_t pop_data_o
);
  import pcir_pkg::*;

  localparam int unsigned PTRW = $clog2(FQ_DEPTH);
  localparam int unsigned CNTW = $clog2(FQ_DEPTH + 1);

  fq_t mem_q [FQ_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != CNTW'(FQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PCIR_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNTW'(FQ_DEPTH))
  `PCIR_ASSERT_NXT(a_cnt_inc, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
  `PCIR_ASSERT_IMP(a_ptr_eq, clk_i, rst_ni, cnt_q == '0 || cnt_q == CNTW'(FQ_DEPTH), wr_ptr_q == rd_ptr_q)

endmodule

// File: rtl/core/pcir_div.sv
// ----------------------------------------------------------------------------
// pcir_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pcir_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pcir_pkg::NUMW-1:0] num_i,
  input  logic [pcir_pkg::TW-1:0]   den_i,
  output logic [pcir_pkg::DW-1:0]   quo_o
);
  import pcir_pkg::*;

  logic [NUMW-1:0] rem_q [DW];
  logic [DW-1:0]   quo_q [DW];
  logic [TW-1:0]   den_q [DW-1];

  for (genvar j = 0; j < DW; j++) begin : g_stage
    localparam int unsigned K = DW - 1 - j;
    logic [NUMW-1:0]    rin;
    logic [TW-1:0]      din;
    logic [DW-1:0]      qin;
    logic [NUMW+TW-1:0] dsh;
    logic               ge;

    if (j == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign din = den_q[j-1];
      assign qin = quo_q[j-1];
    end

    // Try the shifted divisor against the partial remainder
    assign dsh = (NUMW+TW)'(din) << K;
    assign ge  = ({{TW{1'b0}}, rin} >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rin - dsh[NUMW-1:0]) : rin;
        quo_q[j] <= qin | (ge ? (DW'(1) << K) : DW'(0));
      end
    end

    if (j < DW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[j] <= din;
        end
      end
    end
  end

  assign quo_o = quo_q[DW-1];

endmodule

// File: rtl/core/pcir_back.sv
// ----------------------------------------------------------------------------
// pcir_back
// Splits the velocity change and penetration by inverse mass and applies
// them to velocities and positions with saturation.
// ----------------------------------------------------------------------------
module pcir_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  pcir_pkg::fq_t pop_data_i,
  output logic          pop_o,
  pcir_res_if.source    res_o
);
  import pcir_pkg::*;

  logic adv;
  logic [DW+1:0] bv_q;
  logic          ov_q;
  fq_t side_q [DW+1];

  logic [NUMW-1:0] nsa_q, nsb_q, nma_q, nmb_q;
  logic [DW-1:0]   qsa, qsb, qma, qmb;

  logic signed [MPW-1:0] pva_d [3], pvb_d [3], ppa_d [3], ppb_d [3];
  logic signed [MPW-1:0] pva_q [3], pvb_q [3], ppa_q [3], ppb_q [3];
  fq_t ms_q;

  logic [VW-1:0] nva_d, nvb_d, npa_d, npb_d;
  logic [VW-1:0] nva_q, nvb_q, npa_q, npb_q;
  logic          imp_q, mov_q;

  // Add or subtract a scaled product from a component, then saturate
  function automatic logic [CW-1:0] upd(input logic [CW-1:0] base,
                                        input logic signed [MPW-1:0] prod,
                                        input logic sub);
    logic signed [SUMW-1:0] b, d, s, hi, lo;
    b  = SUMW'($signed(base));
    d  = SUMW'($signed(prod[MPW-1:NF]));
    s  = sub ? (b - d) : (b + d);
    hi = SUMW'($signed({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - SUMW'(1);
    if (s > hi) begin
      return hi[CW-1:0];
    end else if (s < lo) begin
      return lo[CW-1:0];
    end
    return s[CW-1:0];
  endfunction

  // Move when the output register is free or being taken
  assign adv   = !ov_q || res_o.ready;
  assign pop_o = adv && pop_valid_i;

  // Dividers for the four inverse-mass shares
  pcir_div u_div_sa (.clk_i, .en_i(adv), .num_i(nsa_q), .den_i(side_q[0].tot), .quo_o(qsa));
  pcir_div u_div_sb (.clk_i, .en_i(adv), .num_i(nsb_q), .den_i(side_q[0].tot), .quo_o(qsb));
  pcir_div u_div_ma (.clk_i, .en_i(adv), .num_i(nma_q), .den_i(side_q[0].tot), .quo_o(qma));
  pcir_div u_div_mb (.clk_i, .en_i(adv), .num_i(nmb_q), .den_i(side_q[0].tot), .quo_o(qmb));

  // Normal times each share
  always_comb begin
    logic signed [CW-1:0] nn;
    for (int i = 0; i < 3; i++) begin
      nn       = $signed(side_q[DW].ctx.nrm[i*CW +: CW]);
      pva_d[i] = nn * $signed({1'b0, qsa});
      pvb_d[i] = nn * $signed({1'b0, qsb});
      ppa_d[i] = nn * $signed({1'b0, qma});
      ppb_d[i] = nn * $signed({1'b0, qmb});
    end
  end

  // Apply the changes where the contact calls for them
  always_comb begin
    nva_d = ms_q.ctx.vel_a;
    nvb_d = ms_q.ctx.vel_b;
    npa_d = ms_q.ctx.pos_a;
    npb_d = ms_q.ctx.pos_b;
    for (int i = 0; i < 3; i++) begin
      if (ms_q.imp) begin
        nva_d[i*CW +: CW] = upd(ms_q.ctx.vel_a[i*CW +: CW], pva_q[i], 1'b0);
        if (ms_q.ctx.has_b) begin
          nvb_d[i*CW +: CW] = upd(ms_q.ctx.vel_b[i*CW +: CW], pvb_q[i], 1'b1);
        end
      end
      if (ms_q.mov) begin
        npa_d[i*CW +: CW] = upd(ms_q.ctx.pos_a[i*CW +: CW], ppa_q[i], 1'b0);
        if (ms_q.ctx.has_b) begin
          npb_d[i*CW +: CW] = upd(ms_q.ctx.pos_b[i*CW +: CW], ppb_q[i], 1'b1);
        end
      end
    end
  end

  // Advance valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      bv_q <= {bv_q[DW:0], pop_valid_i};
      ov_q <= bv_q[DW+1];
    end
  end

  // Advance payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= pop_data_i;
      nsa_q     <= NUMW'(pop_data_i.delta) * NUMW'(pop_data_i.ctx.ima);
      nsb_q     <= NUMW'(pop_data_i.delta) * NUMW'(pop_data_i.ctx.imb);
      nma_q     <= NUMW'(pop_data_i.ctx.pen) * NUMW'(pop_data_i.ctx.ima);
      nmb_q     <= NUMW'(pop_data_i.ctx.pen) * NUMW'(pop_data_i.ctx.imb);
      for (int j = 1; j <= DW; j++) begin
        side_q[j] <= side_q[j-1];
      end
      ms_q  <= side_q[DW];
      pva_q <= pva_d;
      pvb_q <= pvb_d;
      ppa_q <= ppa_d;
      ppb_q <= ppb_d;
      nva_q <= nva_d;
      nvb_q <= nvb_d;
      npa_q <= npa_d;
      npb_q <= npb_d;
      imp_q <= ms_q.imp;
      mov_q <= ms_q.mov;
    end
  end

  assign res_o.valid           = ov_q;
  assign res_o.new_vel_a       = nva_q;
  assign res_o.new_vel_b       = nvb_q;
  assign res_o.new_pos_a       = npa_q;
  assign res_o.new_pos_b       = npb_q;
  assign res_o.impulse_applied = imp_q;
  assign res_o.positions_moved = mov_q;

endmodule

// File: rtl/core/particle_contact_impulse_resolve.sv
// ----------------------------------------------------------------------------
// particle_contact_impulse_resolve
// Resolves one particle contact per request: restitution impulse and
// interpenetration correction, split by inverse mass.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_i    | in        | valid/ready          | velocities, accelerations,
//           |           |                      | positions, normal, masses
//  res_o    | out       | valid/ready          | new velocities, positions,
//           |           |                      | flags
//  apb      | in        | psel/penable/pready  | time_step register
//
//  One contact is taken per cycle when nothing stalls, and a request spends
//  most of its path in the one-bit-per-stage dividers. The front and the
//  back stall separately, with a four-entry queue between them. Reset
//  clears all valids and sets time_step to 1092.
// ----------------------------------------------------------------------------
module particle_contact_impulse_resolve (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [pcir_pkg::PAW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  pcir_req_if.sink                 req_i,
  pcir_res_if.source               res_o
);
  import pcir_pkg::*;

  logic [TSW-1:0] ts_q;
  logic           sel_ts;
  logic           push, push_ready, pop, pop_valid;
  fq_t            push_data, pop_data;

  assign pready = 1'b1;
  assign sel_ts = (paddr[PAW-1:2] == REG_TIME_STEP);
  assign prdata = sel_ts ? 32'(ts_q) : 32'd0;

  // Hold the time step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
    end else if (psel && penable && pwrite && sel_ts) begin
      ts_q <= pwdata[TSW-1:0];
    end
  end

  pcir_front u_front (
    .clk_i,
    .rst_ni,
    .time_step_i  (ts_q),
    .req_i        (req_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  pcir_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  pcir_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

// File: dv/particle_contact_impulse_resolve_tb.sv
// ----------------------------------------------------------------------------
// particle_contact_impulse_resolve_tb
// Drives contact requests through the resolver and checks every result
// against an in-bench model of the impulse and the position correction.
// The model tracks time_step writes made over APB. Both channels idle at
// random, and the bench runs one receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module particle_contact_impulse_resolve_tb;
  import pcir_pkg::*;

  localparam int unsigned LATENCY = 40;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct {
    logic [VW-1:0]   vel_a, vel_b, accel_a, accel_b, pos_a, pos_b, nrm;
    logic [IMW-1:0]  ima, imb;
    logic            has_b;
    logic [PENW-1:0] pen;
    logic [RSTW-1:0] rest;
  } contact_t;

  typedef struct {
    logic [VW-1:0] vel_a, vel_b, pos_a, pos_b;
    logic          imp, mov;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pcir_req_if req ();
  pcir_res_if res ();

  particle_contact_impulse_resolve uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_i(req.sink), .res_o(res.source)
  );

  outcome_t      pending_outcomes[$];
  logic [15:0]   step_q016 = TS_RESET;
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  bit            calm = 1'b0;
  bit            hold_res = 1'b0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    {req.vel_a, req.vel_b, req.accel_a, req.accel_b} = '0;
    {req.pos_a, req.pos_b, req.contact_normal} = '0;
    {req.inv_mass_a, req.inv_mass_b, req.has_second} = '0;
    {req.penetration, req.restitution} = '0;
    res.ready = 1'b0;
  end

  // Abort on a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic longint comp_of(logic [VW-1:0] w, int i);
    return longint'($signed(w[i*CW +: CW]));
  endfunction

  function automatic longint clamp_comp(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic outcome_t resolve_contact(contact_t c);
    outcome_t o;
    longint n[3], nva[3], nvb[3], npa[3], npb[3];
    longint dv, dacc, sep, tot, ns, acc, delta, sa, sb, ma, mb, rv, ra;
    dv = 0;
    dacc = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = comp_of(c.nrm, i);
      rv = comp_of(c.vel_a, i);
      ra = comp_of(c.accel_a, i);
      if (c.has_b) begin
        rv -= comp_of(c.vel_b, i);
        ra -= comp_of(c.accel_b, i);
      end
      dv += rv * n[i];
      dacc += ra * n[i];
      nva[i] = comp_of(c.vel_a, i);
      nvb[i] = comp_of(c.vel_b, i);
      npa[i] = comp_of(c.pos_a, i);
      npb[i] = comp_of(c.pos_b, i);
    end
    sep = dv >>> NF;
    tot = longint'(c.ima) + (c.has_b ? longint'(c.imb) : 0);
    o.imp = 1'b0;
    o.mov = 1'b0;
    // Closing contact: restitution impulse minus built-up acceleration
    if (sep <= 0 && tot > 0) begin
      ns = (-sep * longint'(c.rest)) >>> RSH;
      acc = (dacc * longint'(step_q016)) >>> (NF + 16);
      if (acc < 0) begin
        ns += (acc * longint'(c.rest)) >>> RSH;
        if (ns < 0) ns = 0;
      end
      delta = ns - sep;
      sa = (delta * longint'(c.ima)) / tot;
      sb = (delta * longint'(c.imb)) / tot;
      for (int i = 0; i < 3; i++) begin
        nva[i] = clamp_comp(nva[i] + ((n[i] * sa) >>> NF));
        if (c.has_b) nvb[i] = clamp_comp(nvb[i] - ((n[i] * sb) >>> NF));
      end
      o.imp = 1'b1;
    end
    // Interpenetration: push A along the normal, B against it
    if (c.pen > 0 && tot > 0) begin
      ma = (longint'(c.pen) * longint'(c.ima)) / tot;
      mb = (longint'(c.pen) * longint'(c.imb)) / tot;
      for (int i = 0; i < 3; i++) begin
        npa[i] = clamp_comp(npa[i] + ((n[i] * ma) >>> NF));
        if (c.has_b) npb[i] = clamp_comp(npb[i] - ((n[i] * mb) >>> NF));
      end
      o.mov = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      o.vel_a[i*CW +: CW] = nva[i][CW-1:0];
      o.vel_b[i*CW +: CW] = nvb[i][CW-1:0];
      o.pos_a[i*CW +: CW] = npa[i][CW-1:0];
      o.pos_b[i*CW +: CW] = npb[i][CW-1:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Send one request; hold valid until it is taken
  task automatic send_contact(contact_t c);
    if (!calm && $urandom_range(99) < 27) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.vel_a <= c.vel_a;
    req.vel_b <= c.vel_b;
    req.accel_a <= c.accel_a;
    req.accel_b <= c.accel_b;
    req.pos_a <= c.pos_a;
    req.pos_b <= c.pos_b;
    req.contact_normal <= c.nrm;
    req.inv_mass_a <= c.ima;
    req.inv_mass_b <= c.imb;
    req.has_second <= c.has_b;
    req.penetration <= c.pen;
    req.restitution <= c.rest;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_outcomes.push_back(resolve_contact(c));
  endtask

  task automatic drop_valid();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain();
    drop_valid();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_time_step(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PAW'(REG_TIME_STEP) << 2;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    step_q016 = value;
  endtask

  // Result receiver: random stalls unless calm or held off
  always @(posedge clk_i) begin
    if (hold_res) res.ready <= 1'b0;
    else res.ready <= calm || ($urandom_range(99) >= 21);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result", $time);
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        if (res.new_vel_a !== e.vel_a) begin
          $display("%0t new_vel_a exp %h got %h", $time, e.vel_a, res.new_vel_a);
          errors++;
        end
        if (res.new_vel_b !== e.vel_b) begin
          $display("%0t new_vel_b exp %h got %h", $time, e.vel_b, res.new_vel_b);
          errors++;
        end
        if (res.new_pos_a !== e.pos_a) begin
          $display("%0t new_pos_a exp %h got %h", $time, e.pos_a, res.new_pos_a);
          errors++;
        end
        if (res.new_pos_b !== e.pos_b) begin
          $display("%0t new_pos_b exp %h got %h", $time, e.pos_b, res.new_pos_b);
          errors++;
        end
        if (res.impulse_applied !== e.imp) begin
          $display("%0t impulse_applied exp %b got %b", $time, e.imp,
                   res.impulse_applied);
          errors++;
        end
        if (res.positions_moved !== e.mov) begin
          $display("%0t positions_moved exp %b got %b", $time, e.mov,
                   res.positions_moved);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [VW-1:0] vec3(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic logic [VW-1:0] rand_vec(bit modest);
    if (modest)
      return vec3($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                  $urandom_range(4000) - 2000);
    return VW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [VW-1:0] rand_normal();
    int axis, mag;
    axis = $urandom_range(2);
    mag = $urandom_range(1) ? 16384 : -16384;
    case ($urandom_range(3))
      0: return rand_vec(1'b0);
      1: return vec3(9459, 9459, -9459);
      default: return vec3(axis == 0 ? mag : 0, axis == 1 ? mag : 0,
                           axis == 2 ? mag : 0);
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    bit modest;
    modest = $urandom_range(3) != 0;
    c.vel_a = rand_vec(modest);
    c.vel_b = rand_vec(modest);
    c.accel_a = rand_vec(modest);
    c.accel_b = rand_vec(modest);
    c.pos_a = rand_vec(modest);
    c.pos_b = rand_vec(modest);
    c.nrm = rand_normal();
    c.ima = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom());
    c.imb = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom());
    c.has_b = 1'($urandom_range(1));
    c.pen = ($urandom_range(4) == 0) ? 15'd0 : 15'($urandom());
    c.rest = ($urandom_range(3) == 0) ? 9'($urandom()) : 9'($urandom_range(256));
    return c;
  endfunction

  function automatic contact_t base_contact();
    contact_t c;
    c.vel_a = vec3(-512, 0, 0);
    c.vel_b = vec3(256, 0, 0);
    c.accel_a = vec3(0, -2560, 0);
    c.accel_b = '0;
    c.pos_a = vec3(100, 200, 300);
    c.pos_b = vec3(-100, -200, -300);
    c.nrm = vec3(16384, 0, 0);
    c.ima = 16'd256;
    c.imb = 16'd128;
    c.has_b = 1'b1;
    c.pen = 15'd64;
    c.rest = 9'd128;
    return c;
  endfunction

  task automatic test_directed();
    contact_t c;
    c = base_contact();
    send_contact(c);
    // No B: B data passes through
    c.has_b = 1'b0;
    c.vel_b = 48'hFFFF_FFFF_FFFF;
    send_contact(c);
    // Separating contact
    c = base_contact();
    c.vel_a = vec3(512, 0, 0);
    send_contact(c);
    // Zero total inverse mass, with and without B
    c = base_contact();
    c.ima = '0;
    c.imb = '0;
    send_contact(c);
    c.has_b = 1'b0;
    c.imb = 16'hFFFF;
    send_contact(c);
    // Zero penetration
    c = base_contact();
    c.pen = '0;
    send_contact(c);
    // Restitution extremes
    c.rest = 9'd0;
    send_contact(c);
    c.rest = 9'd256;
    send_contact(c);
    c.rest = 9'd511;
    send_contact(c);
    // Acceleration along the normal, both signs
    c = base_contact();
    c.accel_a = vec3(-32768, 0, 0);
    send_contact(c);
    c.accel_a = vec3(32767, 0, 0);
    send_contact(c);
    // Field extremes and saturation
    c.vel_a = vec3(-32768, -32768, -32768);
    c.vel_b = vec3(32767, 32767, 32767);
    c.accel_a = vec3(-32768, -32768, -32768);
    c.accel_b = vec3(32767, 32767, 32767);
    c.pos_a = vec3(32767, 32767, 32767);
    c.pos_b = vec3(-32768, -32768, -32768);
    c.nrm = vec3(32767, 32767, 32767);
    c.ima = 16'hFFFF;
    c.imb = 16'hFFFF;
    c.pen = 15'h7FFF;
    c.rest = 9'h1FF;
    send_contact(c);
    c.nrm = vec3(-32768, -32768, -32768);
    send_contact(c);
    c.has_b = 1'b0;
    send_contact(c);
    c = base_contact();
    c = '{default: '0};
    send_contact(c);
    // Non-unit normal, A immovable
    c = base_contact();
    c.nrm = vec3(3000, -7000, 11);
    c.ima = '0;
    send_contact(c);
  endtask

  task automatic test_time_step();
    logic [15:0] steps[4];
    steps = '{16'd0, 16'hFFFF, 16'd1, TS_RESET};
    foreach (steps[k]) begin
      write_time_step(steps[k]);
      for (int j = 0; j < 12; j++) send_contact(rand_contact());
      drain();
    end
  endtask

  task automatic test_random(int count);
    for (int j = 0; j < count; j++) begin
      calm = (j >= count / 3) && (j < count / 2);
      send_contact(rand_contact());
    end
    calm = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    fork
      begin
        hold_res = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_res = 1'b0;
      end
      for (int j = 0; j < 40; j++) send_contact(rand_contact());
    join
  endtask

  // Sender pauses until every result has come back
  task automatic test_pause();
    for (int j = 0; j < 10; j++) send_contact(rand_contact());
    drain();
    for (int j = 0; j < 10; j++) send_contact(rand_contact());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_time_step();
    test_backpressure();
    test_pause();
    drain();
    write_time_step(16'd40000);
    test_random(300);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
